>>> design/polynomial_squared_error_sum_defines.svh
// Assertion macros for the polynomial squared error sum block.
// Used by the port checker; expects signals clk and arst_n in the using scope.
`ifndef POLYNOMIAL_SQUARED_ERROR_SUM_DEFINES_SVH
`define POLYNOMIAL_SQUARED_ERROR_SUM_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PSES_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PSES_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/pses_pkg.sv
// Shared types and constants for the polynomial squared error sum block.
// No dependencies; every other file of the block but the defines header imports it.
`default_nettype none

package pses_pkg;

	localparam int PT_W          = 5;   // point coordinate width
	localparam int COEF_W        = 32;  // coefficient width
	localparam int DEG_W         = 3;   // degree register width
	localparam int CFG_IDX_W     = 3;   // configuration register index width
	localparam int NUM_COEF_REGS = 7;
	localparam int EVAL_W        = 48;  // Horner accumulator width
	localparam int SUM_W         = 63;  // running sum width, Q31.32

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic signed [EVAL_W-1:0] EVAL_MAX = {1'b0, {(EVAL_W-1){1'b1}}};
	localparam logic signed [EVAL_W-1:0] EVAL_MIN = {1'b1, {(EVAL_W-1){1'b0}}};

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_RESID,
		ST_SQUARE,
		ST_ACCUM
	} pses_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;    // capture the point and seed the accumulator
		logic step;    // one Horner multiply-add
		logic resid;   // form the residual magnitude
		logic square;  // square the magnitude
		logic accum;   // scale, add to the sum, emit on a last point
	} pses_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic deg_zero;   // constant polynomial, no Horner steps
		logic step_last;  // this Horner step is the final one
		logic last_pt;    // the captured point closes its set
		logic out_busy;   // result register holds a beat not taken this cycle
	} pses_stat_t;

endpackage

`default_nettype wire

>>> design/pses_ifs.sv
// Channel interfaces of the polynomial squared error sum block: point input,
// result output and configuration write. Depends on pses_pkg.
`default_nettype none

interface pses_point_if;
	import pses_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [PT_W-1:0] point_x;
	logic signed [PT_W-1:0] point_y;
	logic                   last_point;
	modport source (output valid, output point_x, output point_y, output last_point,
		input ready);
	modport sink (input valid, input point_x, input point_y, input last_point,
		output ready);
endinterface

interface pses_result_if;
	import pses_pkg::*;
	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] fitness;
	logic             saturated;
	modport source (output valid, output fitness, output saturated, input ready);
	modport sink (input valid, input fitness, input saturated, output ready);
endinterface

interface pses_cfg_if;
	import pses_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COEF_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/pses_cfg.sv
// Configuration register file: degree and coefficients, with the degree clamp.
// Depends on pses_pkg and the pses_cfg_if interface.
`default_nettype none

module pses_cfg #(
	parameter int MAX_COEFFS = 7,
	parameter int IDX_W      = 3
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	pses_cfg_if.sink                                 cfg,
	output logic [IDX_W-1:0]                         deg_eff,
	output logic [MAX_COEFFS-1:0][pses_pkg::COEF_W-1:0] coef
);
	import pses_pkg::*;

	localparam logic [DEG_W-1:0] DEG_MAX = DEG_W'(MAX_COEFFS - 1);

	logic [DEG_W-1:0]                  degree_q;
	logic [MAX_COEFFS-1:0][COEF_W-1:0] coef_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			coef_q   <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == REG_DEGREE) begin
				degree_q <= cfg.data[DEG_W-1:0];
			end
			for (int i = 0; i < MAX_COEFFS; i++) begin
				if (cfg.index == REG_COEF0 + CFG_IDX_W'(i)) begin
					coef_q[i] <= cfg.data;
				end
			end
		end
	end

	// A degree beyond the coefficient storage uses the highest one held.
	assign deg_eff = (degree_q > DEG_MAX) ? IDX_W'(DEG_MAX) : IDX_W'(degree_q);
	assign coef    = coef_q;

endmodule

`default_nettype wire

>>> design/pses_ctrl.sv
// Controller state machine: sequences Horner steps, residual, square and sum.
// Depends on pses_pkg; drives the datapath through pses_cmd_t.
`default_nettype none

module pses_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 point_valid,
	output logic                      point_ready,
	input  wire pses_pkg::pses_stat_t stat,
	output pses_pkg::pses_cmd_t       cmd
);
	import pses_pkg::*;

	pses_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		point_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				point_ready = 1'b1;
				if (point_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.deg_zero ? ST_RESID : ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.step = 1'b1;
				if (stat.step_last) begin
					state_d = ST_RESID;
				end
			end
			ST_RESID: begin
				cmd.resid = 1'b1;
				state_d   = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = ST_ACCUM;
			end
			ST_ACCUM: begin
				// A last point waits here until the result register is free.
				if (!(stat.last_pt && stat.out_busy)) begin
					cmd.accum = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> design/pses_dpath.sv
// Datapath: Horner evaluator, residual, squarer, saturating sum, result register.
// Depends on pses_pkg; controlled by pses_ctrl through pses_cmd_t.
`default_nettype none

module pses_dpath #(
	parameter int MAX_COEFFS = 7,
	parameter int FRAC_BITS  = 16,
	parameter int IDX_W      = 3
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire pses_pkg::pses_cmd_t                    cmd,
	output pses_pkg::pses_stat_t                        stat,
	input  wire logic signed [pses_pkg::PT_W-1:0]       point_x,
	input  wire logic signed [pses_pkg::PT_W-1:0]       point_y,
	input  wire logic                                   last_point,
	input  wire logic [IDX_W-1:0]                       deg_eff,
	input  wire logic [MAX_COEFFS-1:0][pses_pkg::COEF_W-1:0] coef,
	input  wire logic                                   result_ready,
	output logic                                        result_valid,
	output logic [pses_pkg::SUM_W-1:0]                  fitness,
	output logic                                        saturated
);
	import pses_pkg::*;

	localparam int STEP_W  = EVAL_W + PT_W + 1;  // product plus coefficient
	localparam int RES_W   = EVAL_W + 1;
	localparam int SQ_IN_W = 32;
	localparam int SQ_W    = 2 * SQ_IN_W;
	localparam int SH      = 2 * FRAC_BITS - 32;
	localparam int RSH     = (SH > 0) ? SH : 0;
	localparam int LSH     = (SH < 0) ? -SH : 0;

	logic signed [PT_W-1:0]   x_q, y_q;
	logic                     last_q;
	logic [IDX_W-1:0]         cnt_q;
	logic signed [EVAL_W-1:0] acc_q;
	logic [SQ_IN_W-1:0]       mag_q;
	logic                     big_q, big_sq_q;
	logic [SQ_W-1:0]          sq_q;
	logic [SUM_W-1:0]         sum_q;
	logic                     ovf_q;
	logic                     out_valid_q;
	logic [SUM_W-1:0]         fitness_q;
	logic                     sat_q;

	logic [IDX_W-1:0]         rd_idx;
	logic [COEF_W-1:0]        coef_rd;
	logic signed [STEP_W-1:0] step_sum;
	logic                     step_hi, step_lo;
	logic signed [EVAL_W-1:0] step_clamp;
	logic signed [RES_W-1:0]  resid;
	logic [RES_W-1:0]         res_mag;
	logic [SQ_W-1:0]          sq_rs;
	logic [SQ_W-1:0]          sq_sh;
	logic                     v_ovf;
	logic [SUM_W-1:0]         v;
	logic [SUM_W:0]           total;
	logic                     sum_sat;
	logic [SUM_W-1:0]         new_sum;
	logic                     new_ovf;

	// One coefficient read port: the top coefficient on load, the next lower on a step.
	assign rd_idx  = cmd.load ? deg_eff : cnt_q - IDX_W'(1);
	assign coef_rd = coef[rd_idx];

	assign step_sum   = STEP_W'(acc_q) * STEP_W'(x_q) + STEP_W'(signed'(coef_rd));
	assign step_hi    = step_sum > STEP_W'(EVAL_MAX);
	assign step_lo    = step_sum < STEP_W'(EVAL_MIN);
	assign step_clamp = step_hi ? EVAL_MAX : (step_lo ? EVAL_MIN : step_sum[EVAL_W-1:0]);

	assign resid   = (RES_W'(y_q) <<< FRAC_BITS) - RES_W'(acc_q);
	assign res_mag = resid[RES_W-1] ? RES_W'(-resid) : RES_W'(resid);

	// Bring the square to 32 fraction bits; a left shift must not lose top bits.
	assign sq_rs   = sq_q >> RSH;
	assign sq_sh   = sq_rs << LSH;
	assign v_ovf   = big_sq_q || ((sq_rs >> (SUM_W - LSH)) != '0);
	assign v       = v_ovf ? SUM_MAX : sq_sh[SUM_W-1:0];
	assign total   = {1'b0, sum_q} + {1'b0, v};
	assign sum_sat = total[SUM_W];
	assign new_sum = sum_sat ? SUM_MAX : total[SUM_W-1:0];
	assign new_ovf = ovf_q || v_ovf || sum_sat;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= point_x;
			y_q    <= point_y;
			last_q <= last_point;
			cnt_q  <= deg_eff;
			acc_q  <= EVAL_W'(signed'(coef_rd));
		end else if (cmd.step) begin
			cnt_q <= cnt_q - IDX_W'(1);
			acc_q <= step_clamp;
		end
		if (cmd.resid) begin
			mag_q <= res_mag[SQ_IN_W-1:0];
			big_q <= |res_mag[RES_W-1:SQ_IN_W];
		end
		if (cmd.square) begin
			sq_q     <= mag_q * mag_q;
			big_sq_q <= big_q;
		end
		if (cmd.accum && last_q) begin
			fitness_q <= new_sum;
			sat_q     <= new_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step && (step_hi || step_lo)) begin
				ovf_q <= 1'b1;
			end
			if (cmd.accum) begin
				sum_q <= last_q ? '0 : new_sum;
				ovf_q <= last_q ? 1'b0 : new_ovf;
			end
			if (cmd.accum && last_q) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.deg_zero  = (deg_eff == '0);
	assign stat.step_last = (cnt_q == IDX_W'(1));
	assign stat.last_pt   = last_q;
	assign stat.out_busy  = out_valid_q && !result_ready;

	assign result_valid = out_valid_q;
	assign fitness      = fitness_q;
	assign saturated    = sat_q;

endmodule

`default_nettype wire

>>> design/polynomial_squared_error_sum.sv
// Polynomial squared error sum. A point (x, y) is taken only while the block is
// idle, so the next point waits until the last one is through its steps: capture
// the point and load the top coefficient, then as many Horner multiply-adds on the
// single shared 48 by 5 bit multiplier as the degree, which is the configured
// degree clamped to MAX_COEFFS - 1, then the residual, the 32 by 32 bit square and
// the saturating accumulate. A last point emits one result beat holding the sum
// and the overflow flag; the result sits in an output register, so the next set
// can start while it waits to be taken, and only a second last point finding
// that register still full waits in its accumulate cycle. Configuration writes
// are always taken and must only happen while no point is in flight.
`default_nettype none

module polynomial_squared_error_sum #(
	parameter int MAX_COEFFS = 7,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	pses_point_if.sink  point,
	pses_result_if.source result,
	pses_cfg_if.sink    cfg
);
	import pses_pkg::*;

	// Width of a coefficient index, kept at one bit for a constant-only build.
	localparam int IDX_W = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;

	logic [IDX_W-1:0]                  deg_eff;
	logic [MAX_COEFFS-1:0][COEF_W-1:0] coef;
	pses_cmd_t                         cmd;
	pses_stat_t                        stat;
	logic                              point_ready;
	logic                              result_valid;
	logic [SUM_W-1:0]                  fitness;
	logic                              saturated;

	// Register file: degree and coefficients, written over the config channel.
	pses_cfg #(
		.MAX_COEFFS (MAX_COEFFS),
		.IDX_W      (IDX_W)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.deg_eff (deg_eff),
		.coef    (coef)
	);

	// The controller owns the input handshake and steps the datapath.
	pses_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point.valid),
		.point_ready (point_ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	// The datapath holds the point, accumulator, running sum and result register.
	pses_dpath #(
		.MAX_COEFFS (MAX_COEFFS),
		.FRAC_BITS  (FRAC_BITS),
		.IDX_W      (IDX_W)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.point_x      (point.point_x),
		.point_y      (point.point_y),
		.last_point   (point.last_point),
		.deg_eff      (deg_eff),
		.coef         (coef),
		.result_ready (result.ready),
		.result_valid (result_valid),
		.fitness      (fitness),
		.saturated    (saturated)
	);

	assign point.ready      = point_ready;
	assign result.valid     = result_valid;
	assign result.fitness   = fitness;
	assign result.saturated = saturated;

endmodule

`default_nettype wire

>>> design/pses_checker.sv
// Port-level checker for the polynomial squared error sum block, bound to the
// top level. Depends on pses_pkg and polynomial_squared_error_sum_defines.svh.
`default_nettype none
`include "polynomial_squared_error_sum_defines.svh"

module pses_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       point_valid,
	input wire logic                       point_ready,
	input wire logic                       result_valid,
	input wire logic                       result_ready,
	input wire logic [pses_pkg::SUM_W-1:0] fitness,
	input wire logic                       saturated
);
	import pses_pkg::*;

	// A stalled result beat stays offered.
	`PSES_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result beat dropped while stalled")

	// A stalled result beat keeps its payload.
	`PSES_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(fitness) && $stable(saturated), "result payload changed while stalled")

	// Every point occupies the block for at least its capture, residual, square and sum.
	`PSES_ASSERT_NEXT(a_point_busy, point_valid && point_ready, !point_ready ##1 !point_ready ##1 !point_ready, "point accepted again too soon")

	// A result only appears at the end of work on a point.
	`PSES_ASSERT_NOW(a_result_origin, $rose(result_valid), $past(!point_ready), "result appeared while idle")

endmodule

bind polynomial_squared_error_sum pses_checker u_pses_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.point_valid  (point.valid),
	.point_ready  (point.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.fitness      (result.fitness),
	.saturated    (result.saturated)
);

`default_nettype wire

>>> verif/polynomial_squared_error_sum_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for polynomial_squared_error_sum: directed table then random sets.
// Depends on pses_pkg, the channel interfaces in pses_ifs.sv and the block itself.

module polynomial_squared_error_sum_test;
	import pses_pkg::*;

	localparam int MAX_COEFFS     = 7;
	localparam int FRAC_BITS      = 16;
	// This pause covers a point that produces no beat and may still be in flight
	// after the last result.
	localparam int SETTLE_CYCLES  = 16;
	// Longest honest quiet stretch is a sender gap, a full point and a long
	// receiver stall back to back.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 530;

	typedef struct packed {
		logic [SUM_W-1:0] fitness;
		logic             saturated;
	} fit_t;

	typedef enum logic {ROW_CFG, ROW_POINT} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [COEF_W-1:0]     data;
		logic signed [PT_W-1:0] x;
		logic signed [PT_W-1:0] y;
		logic                  last;
		bit                    typed;
		fit_t                  fit;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pses_point_if  point_ch();
	pses_result_if result_ch();
	pses_cfg_if    cfg_ch();

	polynomial_squared_error_sum #(
		.MAX_COEFFS(MAX_COEFFS),
		.FRAC_BITS (FRAC_BITS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.point (point_ch),
		.result(result_ch),
		.cfg   (cfg_ch)
	);

	// Free-running 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow of the block: configuration as it was last written, plus the
	// running sum and overflow flag of the set that is being collected.
	logic [DEG_W-1:0] deg_reg;
	int               coef_reg[NUM_COEF_REGS];
	logic [SUM_W-1:0] sum_acc;
	bit               ovf_seen;

	fit_t      expected_fits[$];   // sums still owed by the block, oldest first
	plan_row_t plan[$];            // the directed table
	int        failures = 0;
	int        burst_left = 0;     // beats left in the sender's current burst
	int        quiet_cycles = 0;

	task automatic note_failure(input string msg);
		$display("ERROR %0t: %s", $time, msg);
		failures++;
	endtask

	// Folds one accepted point into the shadow sum. Horner's rule runs in
	// 64 bits and is clamped to the 48-bit accumulator range at every step;
	// a residual of 2^32 or more, or a square that will not fit the sum,
	// pushes the sum to its ceiling. A last point hands back the sum and
	// starts a fresh set.
	task automatic score_point(input logic signed [PT_W-1:0] px, input logic signed [PT_W-1:0] py,
			input logic last, output bit emits, output fit_t fit);
		longint    acc, xs, resid, ev_hi, ev_lo;
		bit [63:0] mag, sq, addend;
		bit        huge;
		int        top, k, sh;
		ev_hi = EVAL_MAX;
		ev_lo = EVAL_MIN;
		xs = px;
		top = (deg_reg > MAX_COEFFS - 1) ? MAX_COEFFS - 1 : int'(deg_reg);
		acc = coef_reg[top];
		for (k = top - 1; k >= 0; k--) begin
			acc = acc * xs + coef_reg[k];
			if (acc > ev_hi) begin
				acc = ev_hi;
				ovf_seen = 1'b1;
			end else if (acc < ev_lo) begin
				acc = ev_lo;
				ovf_seen = 1'b1;
			end
		end
		resid = longint'(py) * (longint'(1) << FRAC_BITS) - acc;
		mag = (resid < 0) ? -resid : resid;
		sh = 2 * FRAC_BITS - 32;
		sq = '0;
		huge = (mag >= (64'd1 << 32));
		if (!huge) begin
			sq = mag * mag;
			if (sh >= 0)
				sq = sq >> sh;
			else if (sq > (64'(SUM_MAX) >> -sh))
				huge = 1'b1;
			else
				sq = sq << -sh;
			if (sq > 64'(SUM_MAX))
				huge = 1'b1;
		end
		if (huge) begin
			ovf_seen = 1'b1;
			addend = 64'(SUM_MAX);
		end else begin
			addend = sq;
		end
		if (addend > 64'(SUM_MAX) - 64'(sum_acc)) begin
			sum_acc = SUM_MAX;
			ovf_seen = 1'b1;
		end else begin
			sum_acc = sum_acc + addend[SUM_W-1:0];
		end
		emits = last;
		fit.fitness = sum_acc;
		fit.saturated = ovf_seen;
		if (last) begin
			sum_acc = '0;
			ovf_seen = 1'b0;
		end
	endtask

	// One configuration beat; the shadow copy changes when the block takes it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] wdata);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = wdata;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		if (idx == REG_DEGREE)
			deg_reg = wdata[DEG_W-1:0];
		else
			coef_reg[int'(idx) - int'(REG_COEF0)] = wdata;
		@(negedge clk) cfg_ch.valid = 1'b0;
	endtask

	// Sends one point beat. The sender runs in bursts: when a burst is used up
	// valid drops for a random gap (sometimes none) before the next burst.
	// Valid is left high after the beat so back-to-back beats stay back to back.
	task automatic send_point(input logic signed [PT_W-1:0] px, input logic signed [PT_W-1:0] py,
			input logic last, input bit typed, input fit_t typed_fit);
		bit   emits;
		fit_t fit;
		int   gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				point_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		point_ch.valid      = 1'b1;
		point_ch.point_x    = px;
		point_ch.point_y    = py;
		point_ch.last_point = last;
		do @(posedge clk); while (point_ch.ready !== 1'b1);
		score_point(px, py, last, emits, fit);
		// Rows of the table that carry a hand-worked sum are held to that sum.
		if (typed)
			fit = typed_fit;
		if (emits)
			expected_fits = {expected_fits, fit};
	endtask

	// Brings the block to rest: no point offered, every owed sum delivered,
	// then a pause long enough for a point that owes nothing to finish.
	task automatic settle();
		@(negedge clk) point_ch.valid = 1'b0;
		while (expected_fits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] wdata);
		plan_row_t r;
		r.kind  = ROW_CFG;
		r.idx   = idx;
		r.data  = wdata;
		r.x     = '0;
		r.y     = '0;
		r.last  = 1'b0;
		r.typed = 1'b0;
		r.fit   = '0;
		plan = {plan, r};
	endfunction

	function automatic void plan_point(input logic signed [PT_W-1:0] px,
			input logic signed [PT_W-1:0] py, input logic last, input bit typed = 1'b0,
			input logic [SUM_W-1:0] fitness = '0, input logic sat = 1'b0);
		plan_row_t r;
		r.kind          = ROW_POINT;
		r.idx           = '0;
		r.data          = '0;
		r.x             = px;
		r.y             = py;
		r.last          = last;
		r.typed         = typed;
		r.fit.fitness   = fitness;
		r.fit.saturated = sat;
		plan = {plan, r};
	endfunction

	// Random coefficient. The tame style keeps coef_k * 16^k under 2^31 so most
	// residuals stay in range and the sum is exercised away from its ceiling;
	// the raw style sets every bit freely; the last style picks extremes.
	function automatic logic [COEF_W-1:0] draw_coef(input int k, input int style);
		logic [COEF_W-1:0] v;
		int                bits;
		if (style <= 6) begin
			bits = $urandom_range(0, 31 - 4 * k);
			v = $urandom & ((32'd1 << bits) - 32'd1);
			if ($urandom_range(0, 1) == 1)
				v = -v;
		end else if (style <= 8) begin
			v = $urandom;
		end else begin
			case ($urandom_range(0, 4))
				0: v = 32'h7FFF_FFFF;
				1: v = 32'h8000_0000;
				2: v = 32'h0000_0000;
				3: v = 32'h0001_0000;
				default: v = 32'hFFFF_0000;
			endcase
		end
		return v;
	endfunction

	// Result beats are checked field by field against the oldest owed sum.
	always @(posedge clk) begin : result_check
		fit_t owed;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (expected_fits.size() == 0) begin
				note_failure($sformatf("result beat with no sum owed: fitness %h saturated %b",
					result_ch.fitness, result_ch.saturated));
			end else begin
				owed = expected_fits.pop_front();
				if (result_ch.fitness !== owed.fitness)
					note_failure($sformatf("fitness %h, expected %h",
						result_ch.fitness, owed.fitness));
				if (result_ch.saturated !== owed.saturated)
					note_failure($sformatf("saturated %b, expected %b",
						result_ch.saturated, owed.saturated));
			end
		end
	end

	// Receiver back-pressure. Every stretch picks a pattern: always ready,
	// coin flip, ready toggling each cycle, or long stalls with short openings.
	initial begin : result_sink
		int mode, span, stall_left;
		result_ch.ready = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 150);
			repeat (span) @(negedge clk) begin
				case (mode)
					0: result_ch.ready = 1'b1;
					1: result_ch.ready = $urandom_range(0, 1);
					2: result_ch.ready = ~result_ch.ready;
					default: begin
						result_ch.ready = (stall_left == 0);
						if (stall_left > 0)
							stall_left--;
						else if ($urandom_range(0, 3) == 0)
							stall_left = $urandom_range(1, 30);
					end
				endcase
			end
		end
	end

	// Ends a hung run: no beat on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (point_ch.valid && point_ch.ready) ||
				(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("polynomial_squared_error_sum_test failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int  k, s, n, len, style, random_sent, n_sets;
		bit  pending, first_phase;
		logic last;
		fit_t none;

		point_ch.valid      = 1'b0;
		point_ch.point_x    = '0;
		point_ch.point_y    = '0;
		point_ch.last_point = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
		deg_reg  = '0;
		for (k = 0; k < NUM_COEF_REGS; k++)
			coef_reg[k] = 0;
		sum_acc  = '0;
		ovf_seen = 1'b0;
		none     = '0;
		pending  = 1'b0;

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Out of reset the polynomial is zero, so each sum is just the sum of y^2.
		plan_point(0, 0, 1, 1, 63'd0, 0);
		plan_point(-16, -16, 1, 1, 63'd256 << 32, 0);
		plan_point(15, 15, 0);
		plan_point(-16, 0, 1, 1, 63'd225 << 32, 0);
		// p(x) = x: only the last point of this set misses, by five.
		plan_cfg(REG_DEGREE, 32'd1);
		plan_cfg(REG_COEF0 + 3'd1, 32'h0001_0000);
		plan_point(15, 15, 0);
		plan_point(-16, -16, 0);
		plan_point(3, -2, 1, 1, 63'd25 << 32, 0);
		// Degree 7 is read as six; with every coefficient at its maximum the
		// Horner accumulator clamps for large x and the residual is huge.
		plan_cfg(REG_DEGREE, 32'd7);
		for (k = 0; k < NUM_COEF_REGS; k++)
			plan_cfg(REG_COEF0 + 3'(k), 32'h7FFF_FFFF);
		plan_point(-16, 5, 1, 1, SUM_MAX, 1);
		plan_point(0, -16, 1);
		plan_point(1, 15, 1, 1, SUM_MAX, 1);
		// Constant -2^31: each square is just over 2^62, so two of them
		// saturate the sum, and the next set starts clean again.
		plan_cfg(REG_DEGREE, 32'd0);
		for (k = 0; k < NUM_COEF_REGS; k++)
			plan_cfg(REG_COEF0 + 3'(k), 32'h8000_0000);
		plan_point(7, 15, 1);
		plan_point(7, 15, 0);
		plan_point(-3, 15, 1, 1, SUM_MAX, 1);
		plan_point(-9, -16, 1);
		// All coefficients at the minimum: the accumulator clamps negative.
		plan_cfg(REG_DEGREE, 32'd6);
		plan_point(15, 0, 1, 1, SUM_MAX, 1);
		// p(1) = 2^32 - 2 leaves a residual just under 2^32 whose square does
		// not fit; p(-1) = 0 leaves a clean miss by one.
		plan_cfg(REG_DEGREE, 32'd1);
		plan_cfg(REG_COEF0, 32'h7FFF_FFFF);
		plan_cfg(REG_COEF0 + 3'd1, 32'h7FFF_FFFF);
		plan_point(1, 15, 1, 1, SUM_MAX, 1);
		plan_point(-1, -1, 1, 1, 63'd1 << 32, 0);
		// A fractional quadratic, 0.5x^2 - x + 1.5.
		plan_cfg(REG_DEGREE, 32'd2);
		plan_cfg(REG_COEF0, 32'h0001_8000);
		plan_cfg(REG_COEF0 + 3'd1, 32'hFFFF_0000);
		plan_cfg(REG_COEF0 + 3'd2, 32'h0000_8000);
		plan_point(-16, 15, 0);
		plan_point(15, -16, 0);
		plan_point(-1, 0, 0);
		plan_point(8, -8, 0);
		plan_point(5, -11, 1);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				if (pending) begin
					settle();
					pending = 1'b0;
				end
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_point(plan[i].x, plan[i].y, plan[i].last, plan[i].typed, plan[i].fit);
				pending = 1'b1;
			end
		end

		// Random phases: a fresh (sometimes partial) configuration, then a run
		// of sets with random content. Now and then a last flag is flipped, and
		// a phase may end mid-set so the sum carries into the next setting.
		random_sent = 0;
		first_phase = 1'b1;
		while (random_sent < RANDOM_ITEMS) begin
			if (pending) begin
				settle();
				pending = 1'b0;
			end
			style = $urandom_range(0, 9);
			write_reg(REG_DEGREE, 32'($urandom_range(0, 7)));
			for (k = 0; k < NUM_COEF_REGS; k++)
				if (first_phase || $urandom_range(0, 3) != 0)
					write_reg(REG_COEF0 + 3'(k), draw_coef(k, style));
			first_phase = 1'b0;
			n_sets = $urandom_range(3, 10);
			for (s = 0; s < n_sets; s++) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
				for (n = 0; n < len; n++) begin
					last = (n == len - 1);
					if ($urandom_range(0, 15) == 0)
						last = ~last;
					send_point(PT_W'($urandom), PT_W'($urandom), last, 1'b0, none);
					random_sent++;
					pending = 1'b1;
				end
			end
		end

		settle();
		if (failures == 0)
			$display("polynomial_squared_error_sum_test passed");
		else
			$display("polynomial_squared_error_sum_test failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+design
design/pses_pkg.sv
design/pses_ifs.sv
design/pses_cfg.sv
design/pses_ctrl.sv
design/pses_dpath.sv
design/polynomial_squared_error_sum.sv
design/pses_checker.sv
verif/polynomial_squared_error_sum_test.sv
